@@ design/qrs_pkg.sv @@
// Package for the quadratic root solver: result kinds, pipeline depths
// and the sideband record that travels along the square-root pipeline.
// No dependencies.
package qrs_pkg;

  localparam int unsigned MagW      = 34;  // |b*b - 4ac| in Q16.16
  localparam int unsigned RootW     = 32;  // floor(sqrt(|d| * 2^30))
  localparam int unsigned RemW      = 34;  // square-root partial remainder
  localparam int unsigned SqStages  = RootW;
  localparam int unsigned NumW      = 34;  // signed numerator of a quotient
  localparam int unsigned NmagW     = NumW - 1;
  localparam int unsigned DivStages = NmagW;
  localparam int unsigned DenW      = 16;  // |a|
  localparam int unsigned ValW      = 32;

  typedef enum logic [1:0] {
    KIND_COMPLEX  = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_EQUAL    = 2'd2,
    KIND_AZERO    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] nb;     // -b * 2^15
    logic               a_neg;
    logic [DenW-1:0]    a_mag;
  } side_t;

endpackage

@@ design/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: discriminant, square root,
// numerator select, two dividers and the output register. Depends on
// qrs_pkg, qrs_disc, qrs_sqrt and qrs_div.
//
// The solver takes one coefficient set (a, b, c in signed Q8.8) per item and
// returns one result item per input item, in order. It accepts a new item in
// every cycle in which the pipeline advances. Each item passes through the
// discriminant stages, the square root (one root bit per stage), the
// numerator register, the dividers (one quotient bit per stage plus sign
// and saturation) and the output register. All stages advance together;
// when the output item is not taken the whole pipeline holds, so nothing is
// lost or repeated. The root kind travels on tuser; the two values travel on
// tdata. A zero leading coefficient yields kind 3 with both values zero.
module quadratic_root_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] first_value, [63:32] second_value
  output logic [63:0] m_axis_tdata_o,
  // [1:0] root_kind
  output logic [1:0]  m_axis_tuser_o
);
  import qrs_pkg::*;

  // Global advance: the pipeline moves whenever the output register is free
  // or its item is being taken in this cycle.
  logic en;

  logic              disc_valid;
  logic [MagW-1:0]   disc_mag;
  side_t             disc_side;
  logic              sq_valid;
  logic [RootW-1:0]  sq_root;
  side_t             sq_side;

  logic                   num_valid_q;
  logic signed [NumW-1:0] num0_d, num1_d, num0_q, num1_q;
  side_t                  num_side_q;

  logic                   d0_valid, d1_valid;
  logic signed [ValW-1:0] d0_value, d1_value;
  kind_e                  d0_kind, d1_kind;

  logic                   out_valid_q;
  logic signed [ValW-1:0] first_q, second_q;
  kind_e                  kind_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  qrs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .a_i     (s_axis_tdata_i[15:0]),
    .b_i     (s_axis_tdata_i[31:16]),
    .c_i     (s_axis_tdata_i[47:32]),
    .valid_o (disc_valid),
    .mag_o   (disc_mag),
    .side_o  (disc_side)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (disc_valid),
    .mag_i   (disc_mag),
    .side_i  (disc_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Numerators in units of 2^-23: distinct roots use -b*2^15 +/- S, a complex
  // pair uses -b*2^15 for the real part and S for the imaginary part.
  always_comb begin
    logic signed [NumW-1:0] nb_x, s_x;
    nb_x = NumW'(sq_side.nb);
    s_x  = $signed({2'b00, sq_root});
    case (sq_side.kind)
      KIND_DISTINCT: begin
        num0_d = nb_x + s_x;
        num1_d = nb_x - s_x;
      end
      KIND_COMPLEX: begin
        num0_d = nb_x;
        num1_d = s_x;
      end
      default: begin
        num0_d = nb_x;
        num1_d = nb_x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      num_valid_q <= sq_valid;
      out_valid_q <= d0_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q     <= num0_d;
      num1_q     <= num1_d;
      num_side_q <= sq_side;
      kind_q     <= d0_kind;
      // With a zero leading coefficient the quotients are meaningless.
      if (d0_kind == KIND_AZERO) begin
        first_q  <= '0;
        second_q <= '0;
      end else begin
        first_q  <= d0_value;
        second_q <= d1_value;
      end
    end
  end

  qrs_div u_div0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (num_valid_q),
    .num_i     (num0_q),
    .den_neg_i (num_side_q.a_neg),
    .den_mag_i (num_side_q.a_mag),
    .kind_i    (num_side_q.kind),
    .valid_o   (d0_valid),
    .value_o   (d0_value),
    .kind_o    (d0_kind)
  );

  qrs_div u_div1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (num_valid_q),
    .num_i     (num1_q),
    .den_neg_i (num_side_q.a_neg),
    .den_mag_i (num_side_q.a_mag),
    .kind_i    (num_side_q.kind),
    .valid_o   (d1_valid),
    .value_o   (d1_value),
    .kind_o    (d1_kind)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {second_q, first_q};
  assign m_axis_tuser_o  = kind_q;

  // The two dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d0_valid == d1_valid && (!d0_valid || d0_kind == d1_kind))
    else $error("dividers out of step");

  // A zero leading coefficient gives zero values.
  a_azero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_AZERO |-> first_q == '0 && second_q == '0)
    else $error("nonzero values with zero leading coefficient");

  // An equal-root result carries the same value twice.
  a_equal_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_EQUAL |-> first_q == second_q)
    else $error("equal roots differ");

  // An item leaving the dividers while the pipeline moves is registered.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && d0_valid |=> out_valid_q)
    else $error("result dropped at output register");

endmodule

@@ design/qrs_disc.sv @@
// Two-stage discriminant unit: products in the first stage, then
// d = b*b - 4ac, its magnitude, the root kind and -b*2^15.
// Depends on qrs_pkg.
module qrs_disc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [15:0]         a_i,
  input  logic signed [15:0]         b_i,
  input  logic signed [15:0]         c_i,
  output logic                       valid_o,
  output logic [qrs_pkg::MagW-1:0]   mag_o,
  output qrs_pkg::side_t             side_o
);
  import qrs_pkg::*;

  logic [1:0]         valid_q;
  logic [31:0]        bb_q;
  logic signed [31:0] ac_q;
  logic signed [15:0] a_q, b_q;
  logic signed [34:0] d;
  logic [34:0]        dmag;
  logic [MagW-1:0]    mag_q;
  side_t              side_d, side_q;

  always_comb begin
    d    = $signed({3'b000, bb_q}) - $signed({ac_q[31], ac_q, 2'b00});
    dmag = d[34] ? 35'(-d) : d;
    side_d.nb    = -({{16{b_q[15]}}, b_q} <<< 15);
    side_d.a_neg = a_q[15];
    side_d.a_mag = a_q[15] ? 16'(-a_q) : a_q;
    if (a_q == 16'sd0) begin
      side_d.kind = KIND_AZERO;
    end else if (d[34]) begin
      side_d.kind = KIND_COMPLEX;
    end else if (d != 35'sd0) begin
      side_d.kind = KIND_DISTINCT;
    end else begin
      side_d.kind = KIND_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q   <= 32'(b_i * b_i);
      ac_q   <= a_i * c_i;
      a_q    <= a_i;
      b_q    <= b_i;
      mag_q  <= dmag[MagW-1:0];
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q[1];
  assign mag_o   = mag_q;
  assign side_o  = side_q;

endmodule

@@ design/qrs_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, of |d| * 2^30.
// The sideband record rides along. Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [qrs_pkg::MagW-1:0]  mag_i,
  input  qrs_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [qrs_pkg::RootW-1:0] root_o,
  output qrs_pkg::side_t            side_o
);
  import qrs_pkg::*;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  logic [SqStages-1:0] valid_q;
  sq_t                 st_d   [SqStages];
  sq_t                 st_q   [SqStages];
  logic [MagW-1:0]     mag_q  [SqStages];
  side_t               side_q [SqStages];

  function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
    logic [RemW+1:0] rp;
    logic [RemW+1:0] trial;
    sq_t             nxt;
    rp    = {cur.rem, pair};
    trial = (RemW+2)'({cur.root, 2'b01});
    if (rp >= trial) begin
      nxt.rem  = RemW'(rp - trial);
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = RemW'(rp);
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  always_comb begin
    logic [63:0] rad;
    rad      = {mag_i, 30'd0};
    st_d[0]  = sq_step('0, rad[63:62]);
    for (int k = 1; k < SqStages; k++) begin
      rad     = {mag_q[k-1], 30'd0};
      st_d[k] = sq_step(st_q[k-1], rad[2*(SqStages-1-k)+1 -: 2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SqStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0]  <= mag_i;
      side_q[0] <= side_i;
      for (int k = 0; k < SqStages; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < SqStages; k++) begin
        mag_q[k]  <= mag_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[SqStages-1];
  assign root_o  = st_q[SqStages-1].root;
  assign side_o  = side_q[SqStages-1];

endmodule

@@ design/qrs_div.sv @@
// Pipelined signed divider: magnitude stage, one quotient bit per stage,
// then sign and saturation to 32 bits. Depends on qrs_pkg.
module qrs_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [qrs_pkg::NumW-1:0] num_i,
  input  logic                            den_neg_i,
  input  logic [qrs_pkg::DenW-1:0]        den_mag_i,
  input  qrs_pkg::kind_e                  kind_i,
  output logic                            valid_o,
  output logic signed [qrs_pkg::ValW-1:0] value_o,
  output qrs_pkg::kind_e                  kind_o
);
  import qrs_pkg::*;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [NmagW-1:0] quo;
  } dv_t;

  logic                 v0_q, vout_q;
  logic [DivStages-1:0] valid_q;
  logic [NmagW-1:0]     nmag0_q;
  logic                 neg0_q;
  logic [DenW-1:0]      den0_q;
  kind_e                kind0_q, kind_out_q;
  dv_t                  st_d    [DivStages];
  dv_t                  st_q    [DivStages];
  logic [NmagW-1:0]     nmag_q  [DivStages];
  logic                 neg_q   [DivStages];
  logic [DenW-1:0]      den_q   [DivStages];
  kind_e                kind_q  [DivStages];
  logic signed [NmagW+1:0] sval;
  logic signed [ValW-1:0]  sat_d, value_q;

  function automatic dv_t dv_step(dv_t cur, logic nbit, logic [DenW-1:0] den);
    logic [DenW:0] rp;
    dv_t           nxt;
    rp = {cur.rem, nbit};
    if (rp >= {1'b0, den}) begin
      nxt.rem = DenW'(rp - {1'b0, den});
      nxt.quo = {cur.quo[NmagW-2:0], 1'b1};
    end else begin
      nxt.rem = DenW'(rp);
      nxt.quo = {cur.quo[NmagW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  always_comb begin
    st_d[0] = dv_step('0, nmag0_q[NmagW-1], den0_q);
    for (int k = 1; k < DivStages; k++) begin
      st_d[k] = dv_step(st_q[k-1], nmag_q[k-1][NmagW-1-k], den_q[k-1]);
    end
    sval = neg_q[DivStages-1] ? -$signed({2'b00, st_q[DivStages-1].quo})
                              :  $signed({2'b00, st_q[DivStages-1].quo});
    if (sval > $signed((NmagW+2)'(32'h7fffffff))) begin
      sat_d = 32'sh7fffffff;
    end else if (sval < -$signed((NmagW+2)'(33'h080000000))) begin
      sat_d = 32'sh80000000;
    end else begin
      sat_d = sval[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      valid_q <= '0;
      vout_q  <= 1'b0;
    end else if (en_i) begin
      v0_q    <= valid_i;
      valid_q <= {valid_q[DivStages-2:0], v0_q};
      vout_q  <= valid_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag0_q    <= num_i[NumW-1] ? NmagW'(-num_i) : NmagW'(num_i);
      neg0_q     <= num_i[NumW-1] ^ den_neg_i;
      den0_q     <= den_mag_i;
      kind0_q    <= kind_i;
      nmag_q[0]  <= nmag0_q;
      neg_q[0]   <= neg0_q;
      den_q[0]   <= den0_q;
      kind_q[0]  <= kind0_q;
      for (int k = 0; k < DivStages; k++) begin
        st_q[k] <= st_d[k];
      end
      for (int k = 1; k < DivStages; k++) begin
        nmag_q[k] <= nmag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        den_q[k]  <= den_q[k-1];
        kind_q[k] <= kind_q[k-1];
      end
      value_q    <= sat_d;
      kind_out_q <= kind_q[DivStages-1];
    end
  end

  assign valid_o = vout_q;
  assign value_o = value_q;
  assign kind_o  = kind_out_q;

endmodule

@@ bench/tb_quadratic_root_solver.sv @@
// Testbench for quadratic_root_solver: streams coefficient sets through the
// block and checks each root item against an in-bench predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  typedef struct packed {
    logic [15:0] coef_c;
    logic [15:0] coef_b;
    logic [15:0] coef_a;
  } coef_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] first_v;
    logic [31:0] second_v;
  } roots_t;

  localparam int unsigned Latency = 71;
  localparam longint unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_data;
  logic [1:0]  m_user;

  coef_t  pending_coefs[$];
  roots_t expected_roots[$];
  int     n_errors = 0;
  int     n_checked = 0;
  int     kind_seen[4] = '{0, 0, 0, 0};
  longint unsigned cycle_cnt = 0;
  logic   calm = 1'b0;   // long stretch with no idling on either side
  logic   feed_done = 1'b0;

  always #5 clk_i = ~clk_i;

  quadratic_root_solver DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  // Integer floor square root by the bitwise method.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Roots in Q16.16: SV division truncates toward zero like the block.
  function automatic roots_t solve_roots(coef_t cf);
    roots_t r;
    longint a, b, c, disc, sroot, nb;
    longint unsigned mag;
    a = longint'($signed(cf.coef_a));
    b = longint'($signed(cf.coef_b));
    c = longint'($signed(cf.coef_c));
    if (a == 0) begin
      r.kind = KIND_AZERO;
      r.first_v = '0;
      r.second_v = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    mag = (disc < 0) ? -disc : disc;
    sroot = longint'(floor_sqrt(mag << 30));
    nb = -b * 32768;
    if (disc < 0) begin
      r.kind = KIND_COMPLEX;
      r.first_v = clamp32(nb / a);
      r.second_v = clamp32(sroot / a);
    end else if (disc > 0) begin
      r.kind = KIND_DISTINCT;
      r.first_v = clamp32((nb + sroot) / a);
      r.second_v = clamp32((nb - sroot) / a);
    end else begin
      r.kind = KIND_EQUAL;
      r.first_v = clamp32(nb / a);
      r.second_v = r.first_v;
    end
    return r;
  endfunction

  function automatic coef_t pack_coefs(int a, int b, int c);
    coef_t cf;
    cf.coef_a = a[15:0];
    cf.coef_b = b[15:0];
    cf.coef_c = c[15:0];
    return cf;
  endfunction

  // Builds a set whose discriminant is exactly zero: b = 2*k*m, a = k*k, c = m*m.
  function automatic coef_t equal_root_set();
    int k, m;
    k = $urandom_range(1, 100) * (($urandom_range(0, 1) != 0) ? -1 : 1);
    m = $urandom_range(0, 100);
    return pack_coefs(k * k, 2 * k * m * (($urandom_range(0, 1) != 0) ? -1 : 1), m * m);
  endfunction

  initial begin
    int sel;
    int extremes[5] = '{-32768, -1, 0, 1, 32767};
    foreach (extremes[i])
      pending_coefs.push_back(pack_coefs(extremes[i], extremes[(i + 2) % 5],
                                         extremes[(i + 4) % 5]));
    pending_coefs.push_back(pack_coefs(0, 1234, -77));          // leading zero
    pending_coefs.push_back(pack_coefs(256, 0, 256));           // complex pair
    pending_coefs.push_back(pack_coefs(-256, 0, 256));          // negative a, distinct
    pending_coefs.push_back(pack_coefs(256, -768, 512));        // distinct real
    pending_coefs.push_back(pack_coefs(-256, 768, -512));       // negative a, distinct
    pending_coefs.push_back(pack_coefs(256, 512, 256));         // equal roots
    pending_coefs.push_back(pack_coefs(1, 32767, 0));           // large negative root
    pending_coefs.push_back(pack_coefs(1, -32768, 0));          // saturates high
    pending_coefs.push_back(pack_coefs(1, 0, -32768));          // distinct roots of opposite sign
    pending_coefs.push_back(pack_coefs(-32768, -32768, -32768));
    pending_coefs.push_back(pack_coefs(32767, 32767, 32767));
    pending_coefs.push_back(pack_coefs(-1, 0, 32767));
    pending_coefs.push_back(equal_root_set());
    for (int i = 0; i < 600; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) pending_coefs.push_back(equal_root_set());
      else if (sel == 1) pending_coefs.push_back(pack_coefs(0, $urandom, $urandom));
      else if (sel <= 3)
        pending_coefs.push_back(pack_coefs($urandom_range(0, 15) - 8,
                                           $urandom, $urandom));
      else pending_coefs.push_back(coef_t'($urandom ^ ({$urandom} << 16)));
    end
    feed_done = 1'b1;
  end

  // Reset, idle-free window and end of run.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(posedge clk_i);
    calm <= 1'b1;
    repeat (400) @(posedge clk_i);
    calm <= 1'b0;
    wait (feed_done && pending_coefs.size() == 0 && !s_valid &&
          expected_roots.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Checked %0d root items: %0d complex, %0d distinct, %0d equal, %0d with a = 0.",
             n_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (n_errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver test passed");
    end else begin
      $display("quadratic_root_solver test failed");
    end
    $finish;
  end

  // Driver: offer the next coefficient set, idling about a quarter of the time.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("quadratic_root_solver test failed");
      $finish;
    end
    if (rst_ni) begin
      if (!s_valid || s_ready) begin
        if (s_valid) expected_roots.push_back(solve_roots(coef_t'(s_data)));
        if (pending_coefs.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
          s_data <= pending_coefs.pop_front();
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= calm || $urandom_range(0, 99) >= 24;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    roots_t exp_r;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result item kind=%0d data=%h", m_user, m_data);
        n_errors++;
      end else begin
        exp_r = expected_roots.pop_front();
        n_checked++;
        kind_seen[exp_r.kind]++;
        if (m_user !== exp_r.kind) begin
          $error("root_kind: expected %0d, got %0d", exp_r.kind, m_user);
          n_errors++;
        end
        if (m_data[31:0] !== exp_r.first_v) begin
          $error("first_value: expected %0d, got %0d",
                 $signed(exp_r.first_v), $signed(m_data[31:0]));
          n_errors++;
        end
        if (m_data[63:32] !== exp_r.second_v) begin
          $error("second_value: expected %0d, got %0d",
                 $signed(exp_r.second_v), $signed(m_data[63:32]));
          n_errors++;
        end
      end
    end
  end

endmodule
